// File: rtl/core/dpb_pkg.sv
// types, widths and reset values shared by the depth back-projection block
`timescale 1ns / 1ps

package dpb_pkg;

  localparam int unsigned DPB_SAMPLE_STEP = 4;

  localparam int unsigned DPB_COORD_W    = 12;
  localparam int unsigned DPB_DEPTH_W    = 16;
  localparam int unsigned DPB_COLOR_W    = 8;
  localparam int unsigned DPB_INV_W      = 24;
  localparam int unsigned DPB_ROT_W      = 18;
  localparam int unsigned DPB_ROW_W      = 3 * DPB_ROT_W;
  localparam int unsigned DPB_TRN_W      = 21;
  localparam int unsigned DPB_TRN_PACK_W = 3 * DPB_TRN_W;
  localparam int unsigned DPB_WORLD_W    = 32;
  localparam int unsigned DPB_CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    DPB_REG_INV_FX,
    DPB_REG_INV_FY,
    DPB_REG_CX,
    DPB_REG_CY,
    DPB_REG_ROT0,
    DPB_REG_ROT1,
    DPB_REG_ROT2,
    DPB_REG_TRN
  } cfg_idx_e;

  localparam logic [DPB_INV_W-1:0]      DPB_INV_FX_RST = 24'd41943;
  localparam logic [DPB_INV_W-1:0]      DPB_INV_FY_RST = 24'd41943;
  localparam logic [DPB_COORD_W-1:0]    DPB_CX_RST     = 12'd512;
  localparam logic [DPB_COORD_W-1:0]    DPB_CY_RST     = 12'd384;
  localparam logic [DPB_ROW_W-1:0]      DPB_ROT0_RST   = 54'd65536;
  localparam logic [DPB_ROW_W-1:0]      DPB_ROT1_RST   = 54'd17179869184;
  localparam logic [DPB_ROW_W-1:0]      DPB_ROT2_RST   = 54'd4503599627370496;
  localparam logic [DPB_TRN_PACK_W-1:0] DPB_TRN_RST    = 63'd0;

  typedef struct packed {
    logic [DPB_COORD_W-1:0] pixel_col;
    logic [DPB_COORD_W-1:0] pixel_row;
    logic [DPB_DEPTH_W-1:0] depth_value;
    logic [DPB_COLOR_W-1:0] blue_in;
    logic [DPB_COLOR_W-1:0] green_in;
    logic [DPB_COLOR_W-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [DPB_WORLD_W-1:0] world_x;
    logic signed [DPB_WORLD_W-1:0] world_y;
    logic signed [DPB_WORLD_W-1:0] world_z;
    logic [DPB_COLOR_W-1:0]        red_out;
    logic [DPB_COLOR_W-1:0]        green_out;
    logic [DPB_COLOR_W-1:0]        blue_out;
  } point_t;

  typedef struct packed {
    logic [DPB_COLOR_W-1:0] red;
    logic [DPB_COLOR_W-1:0] green;
    logic [DPB_COLOR_W-1:0] blue;
  } color_t;

endpackage

// File: rtl/core/dpb_if.sv
// request channel interfaces: pixels in, world points out, register writes
`timescale 1ns / 1ps

interface dpb_pixel_if;
  logic            valid;
  logic            ready;
  dpb_pkg::pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpb_point_if;
  logic            valid;
  logic            ready;
  dpb_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpb_cfg_if;
  logic                                valid;
  logic                                ready;
  dpb_pkg::cfg_idx_e                   index;
  logic [dpb_pkg::DPB_CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/depth_pixel_backprojection.sv
// pinhole depth back-projection to world space, seven-stage pipeline
//
//   channel   dir  modport  payload
//   cfg_i     in   sink     index (register number), data (64 bit)
//   pixel_i   in   sink     pixel_col, pixel_row, depth_value, blue/green/red_in
//   point_o   out  source   world_x/y/z, red/green/blue_out
//
// one pixel accepted per cycle unless point_o stalls a full pipeline
// the stages in order are (u-c)*d, *1/f, rounding, rotation, two adder stages
// and the saturating output register
// dropped pixels are accepted and leave no result; empty stages fill while stalled
// rst_ni clears the valid bits and loads the default camera registers
`timescale 1ns / 1ps

module depth_pixel_backprojection (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpb_cfg_if.sink     cfg_i,
  dpb_pixel_if.sink   pixel_i,
  dpb_point_if.source point_o
);

  localparam int unsigned NSTAGE = 7;
  localparam int unsigned LAST   = NSTAGE - 1;

  localparam int unsigned GRID_SHIFT = 16;
  localparam int unsigned GRID_MUL   = (1 << GRID_SHIFT) / dpb_pkg::DPB_SAMPLE_STEP;
  localparam logic [GRID_SHIFT:0] GRID_MUL_C = (GRID_SHIFT + 1)'(GRID_MUL);
  localparam logic [4:0]          STEP_C     = 5'(dpb_pkg::DPB_SAMPLE_STEP);

  // grid test for a column or row: approximate quotient leaves a remainder below twice the step
  function automatic logic on_grid(logic [dpb_pkg::DPB_COORD_W-1:0] c);
    logic [28:0] prod;
    logic [11:0] quo;
    logic [16:0] back;
    logic [16:0] rem;
    prod = c * GRID_MUL_C;
    quo  = prod[27:16];
    back = quo * STEP_C;
    rem  = 17'(c) - back;
    return (rem == 17'd0) || (rem == 17'(STEP_C));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [dpb_pkg::DPB_INV_W-1:0]      inv_fx_q, inv_fy_q;
  logic [dpb_pkg::DPB_COORD_W-1:0]    cx_q, cy_q;
  logic [dpb_pkg::DPB_ROW_W-1:0]      rot_q [3];
  logic [dpb_pkg::DPB_TRN_PACK_W-1:0] trn_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q <= dpb_pkg::DPB_INV_FX_RST;
      inv_fy_q <= dpb_pkg::DPB_INV_FY_RST;
      cx_q     <= dpb_pkg::DPB_CX_RST;
      cy_q     <= dpb_pkg::DPB_CY_RST;
      rot_q[0] <= dpb_pkg::DPB_ROT0_RST;
      rot_q[1] <= dpb_pkg::DPB_ROT1_RST;
      rot_q[2] <= dpb_pkg::DPB_ROT2_RST;
      trn_q    <= dpb_pkg::DPB_TRN_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        dpb_pkg::DPB_REG_INV_FX: inv_fx_q <= cfg_i.data[dpb_pkg::DPB_INV_W-1:0];
        dpb_pkg::DPB_REG_INV_FY: inv_fy_q <= cfg_i.data[dpb_pkg::DPB_INV_W-1:0];
        dpb_pkg::DPB_REG_CX:     cx_q     <= cfg_i.data[dpb_pkg::DPB_COORD_W-1:0];
        dpb_pkg::DPB_REG_CY:     cy_q     <= cfg_i.data[dpb_pkg::DPB_COORD_W-1:0];
        dpb_pkg::DPB_REG_ROT0:   rot_q[0] <= cfg_i.data[dpb_pkg::DPB_ROW_W-1:0];
        dpb_pkg::DPB_REG_ROT1:   rot_q[1] <= cfg_i.data[dpb_pkg::DPB_ROW_W-1:0];
        dpb_pkg::DPB_REG_ROT2:   rot_q[2] <= cfg_i.data[dpb_pkg::DPB_ROW_W-1:0];
        dpb_pkg::DPB_REG_TRN:    trn_q    <= cfg_i.data[dpb_pkg::DPB_TRN_PACK_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [17:0] rot_e [3][3];
  logic signed [20:0] trn_e [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rot_e[i][k] = rot_q[i][18*k +: 18];
      end
      trn_e[i] = trn_q[21*i +: 21];
    end
  end

  // stage control
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] en;
  logic              keep;

  always_comb begin
    en[LAST] = !vld_q[LAST] || point_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign keep = (pixel_i.data.depth_value != '0) && on_grid(pixel_i.data.pixel_col)
                && on_grid(pixel_i.data.pixel_row);
  assign pixel_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pixel_i.valid && keep;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // datapath
  logic signed [12:0] dx_w, dy_w;
  logic signed [29:0] m1x_w, m1y_w;
  logic signed [28:0] m1x_q, m1y_q;
  logic [15:0]        d0_q, d1_q, d2_q;
  dpb_pkg::color_t    color_q [LAST];

  logic signed [52:0] p2x_q, p2y_q;
  logic signed [52:0] rnx_w, rny_w;
  logic signed [36:0] px_q, py_q;

  logic signed [36:0] plx_w [3], phx_w [3], ply_w [3], phy_w [3];
  logic signed [42:0] pz_w [3];
  logic signed [36:0] plx_q [3], phx_q [3], ply_q [3], phy_q [3];
  logic signed [42:0] pz_q [3];

  logic signed [55:0] sx_w [3], sy_w [3];
  logic signed [45:0] sz_w [3];
  logic signed [55:0] sx_q [3], sy_q [3];
  logic signed [45:0] sz_q [3];

  logic signed [56:0] acc_w [3];
  logic signed [32:0] fl_q [3];

  dpb_pkg::point_t    out_q;

  always_comb begin
    dx_w  = $signed({1'b0, pixel_i.data.pixel_col}) - $signed({1'b0, cx_q});
    dy_w  = $signed({1'b0, pixel_i.data.pixel_row}) - $signed({1'b0, cy_q});
    m1x_w = dx_w * $signed({1'b0, pixel_i.data.depth_value});
    m1y_w = dy_w * $signed({1'b0, pixel_i.data.depth_value});
    rnx_w = p2x_q + 53'sd32768;
    rny_w = p2y_q + 53'sd32768;
    for (int i = 0; i < 3; i++) begin
      plx_w[i] = rot_e[i][0] * $signed({1'b0, px_q[17:0]});
      phx_w[i] = rot_e[i][0] * $signed(px_q[36:18]);
      ply_w[i] = rot_e[i][1] * $signed({1'b0, py_q[17:0]});
      phy_w[i] = rot_e[i][1] * $signed(py_q[36:18]);
      pz_w[i]  = rot_e[i][2] * $signed({1'b0, d2_q, 8'b0});
      sx_w[i]  = (56'(phx_q[i]) <<< 18) + 56'(plx_q[i]);
      sy_w[i]  = (56'(phy_q[i]) <<< 18) + 56'(ply_q[i]);
      sz_w[i]  = 46'(pz_q[i]) + (46'(trn_e[i]) <<< 24) + 46'sd8388608;
      acc_w[i] = 57'(sx_q[i]) + 57'(sy_q[i]) + 57'(sz_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m1x_q      <= m1x_w[28:0];
      m1y_q      <= m1y_w[28:0];
      d0_q       <= pixel_i.data.depth_value;
      color_q[0] <= '{red: pixel_i.data.red_in, green: pixel_i.data.green_in,
                      blue: pixel_i.data.blue_in};
    end
    for (int k = 1; k < LAST; k++) begin
      if (en[k]) begin
        color_q[k] <= color_q[k-1];
      end
    end
    if (en[1]) begin
      p2x_q <= m1x_q * $signed({1'b0, inv_fx_q});
      p2y_q <= m1y_q * $signed({1'b0, inv_fy_q});
      d1_q  <= d0_q;
    end
    if (en[2]) begin
      px_q <= rnx_w[52:16];
      py_q <= rny_w[52:16];
      d2_q <= d1_q;
    end
    for (int i = 0; i < 3; i++) begin
      if (en[3]) begin
        plx_q[i] <= plx_w[i];
        phx_q[i] <= phx_w[i];
        ply_q[i] <= ply_w[i];
        phy_q[i] <= phy_w[i];
        pz_q[i]  <= pz_w[i];
      end
      if (en[4]) begin
        sx_q[i] <= sx_w[i];
        sy_q[i] <= sy_w[i];
        sz_q[i] <= sz_w[i];
      end
      if (en[5]) begin
        fl_q[i] <= acc_w[i][56:24];
      end
    end
    if (en[LAST]) begin
      out_q.world_x   <= sat32(fl_q[0]);
      out_q.world_y   <= sat32(fl_q[1]);
      out_q.world_z   <= sat32(fl_q[2]);
      out_q.red_out   <= color_q[LAST-1].red;
      out_q.green_out <= color_q[LAST-1].green;
      out_q.blue_out  <= color_q[LAST-1].blue;
    end
  end

  assign point_o.valid = vld_q[LAST];
  assign point_o.data  = out_q;

  a_drop_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_i.valid && pixel_i.ready && pixel_i.data.depth_value == '0) |=> !vld_q[0])
    else $error("zero-depth pixel entered the pipeline");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_i.ready |-> vld_q[0])
    else $error("input stalled with an empty first stage");

  a_bubble_collapse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[1] |-> en[0])
    else $error("empty second stage did not open the input");

  a_stalled_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !en[3]) |=> vld_q[3])
    else $error("stalled rotation stage lost its pixel");

endmodule

// File: bench/dpb_point_checker.sv
// checker: watches the three channels, predicts each world point and compares
`timescale 1ns / 1ps

module dpb_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpb_cfg_if          cfg_mon,
  dpb_pixel_if        pixel_mon,
  dpb_point_if        point_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam longint WORLD_MAX = 64'sd2147483647;
  localparam longint WORLD_MIN = -64'sd2147483648;

  logic [dpb_pkg::DPB_INV_W-1:0]      cam_inv_fx;
  logic [dpb_pkg::DPB_INV_W-1:0]      cam_inv_fy;
  logic [dpb_pkg::DPB_COORD_W-1:0]    cam_cx;
  logic [dpb_pkg::DPB_COORD_W-1:0]    cam_cy;
  logic [dpb_pkg::DPB_ROW_W-1:0]      cam_rot0;
  logic [dpb_pkg::DPB_ROW_W-1:0]      cam_rot1;
  logic [dpb_pkg::DPB_ROW_W-1:0]      cam_rot2;
  logic [dpb_pkg::DPB_TRN_PACK_W-1:0] cam_trn;

  dpb_pkg::point_t expected_points[$];
  int unsigned     mismatches;

  // round half up, then drop s fraction bits
  function automatic longint round_q(longint v, int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [dpb_pkg::DPB_WORLD_W-1:0] world_axis(
    logic [dpb_pkg::DPB_ROW_W-1:0] row, longint cam_x, longint cam_y, longint cam_z,
    logic [dpb_pkg::DPB_TRN_W-1:0] offset
  );
    longint acc;
    acc = longint'($signed(row[dpb_pkg::DPB_ROT_W-1:0])) * cam_x
        + longint'($signed(row[2*dpb_pkg::DPB_ROT_W-1:dpb_pkg::DPB_ROT_W])) * cam_y
        + longint'($signed(row[3*dpb_pkg::DPB_ROT_W-1:2*dpb_pkg::DPB_ROT_W])) * cam_z
        + (longint'($signed(offset)) <<< 24);
    acc = round_q(acc, 24);
    if (acc > WORLD_MAX) acc = WORLD_MAX;
    if (acc < WORLD_MIN) acc = WORLD_MIN;
    return acc[dpb_pkg::DPB_WORLD_W-1:0];
  endfunction

  function automatic bit project_pixel(dpb_pkg::pixel_t px, output dpb_pkg::point_t pt);
    longint cam_x, cam_y, cam_z;
    pt = '0;
    if (px.depth_value == '0) return 1'b0;
    if ((px.pixel_col % dpb_pkg::DPB_SAMPLE_STEP) != 0
        || (px.pixel_row % dpb_pkg::DPB_SAMPLE_STEP) != 0)
      return 1'b0;
    cam_x = round_q((longint'(px.pixel_col) - longint'(cam_cx)) * longint'(px.depth_value)
                    * longint'(cam_inv_fx), 16);
    cam_y = round_q((longint'(px.pixel_row) - longint'(cam_cy)) * longint'(px.depth_value)
                    * longint'(cam_inv_fy), 16);
    cam_z = longint'(px.depth_value) <<< 8;
    pt.world_x   = world_axis(cam_rot0, cam_x, cam_y, cam_z,
                              cam_trn[dpb_pkg::DPB_TRN_W-1:0]);
    pt.world_y   = world_axis(cam_rot1, cam_x, cam_y, cam_z,
                              cam_trn[2*dpb_pkg::DPB_TRN_W-1:dpb_pkg::DPB_TRN_W]);
    pt.world_z   = world_axis(cam_rot2, cam_x, cam_y, cam_z,
                              cam_trn[3*dpb_pkg::DPB_TRN_W-1:2*dpb_pkg::DPB_TRN_W]);
    pt.red_out   = px.red_in;
    pt.green_out = px.green_in;
    pt.blue_out  = px.blue_in;
    return 1'b1;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dpb_pkg::point_t got;
    dpb_pkg::point_t want;
    if (!rst_ni) begin
      cam_inv_fx = dpb_pkg::DPB_INV_FX_RST;
      cam_inv_fy = dpb_pkg::DPB_INV_FY_RST;
      cam_cx     = dpb_pkg::DPB_CX_RST;
      cam_cy     = dpb_pkg::DPB_CY_RST;
      cam_rot0   = dpb_pkg::DPB_ROT0_RST;
      cam_rot1   = dpb_pkg::DPB_ROT1_RST;
      cam_rot2   = dpb_pkg::DPB_ROT2_RST;
      cam_trn    = dpb_pkg::DPB_TRN_RST;
      expected_points.delete();
      mismatches = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          dpb_pkg::DPB_REG_INV_FX: cam_inv_fx = cfg_mon.data[dpb_pkg::DPB_INV_W-1:0];
          dpb_pkg::DPB_REG_INV_FY: cam_inv_fy = cfg_mon.data[dpb_pkg::DPB_INV_W-1:0];
          dpb_pkg::DPB_REG_CX:     cam_cx     = cfg_mon.data[dpb_pkg::DPB_COORD_W-1:0];
          dpb_pkg::DPB_REG_CY:     cam_cy     = cfg_mon.data[dpb_pkg::DPB_COORD_W-1:0];
          dpb_pkg::DPB_REG_ROT0:   cam_rot0   = cfg_mon.data[dpb_pkg::DPB_ROW_W-1:0];
          dpb_pkg::DPB_REG_ROT1:   cam_rot1   = cfg_mon.data[dpb_pkg::DPB_ROW_W-1:0];
          dpb_pkg::DPB_REG_ROT2:   cam_rot2   = cfg_mon.data[dpb_pkg::DPB_ROW_W-1:0];
          dpb_pkg::DPB_REG_TRN:    cam_trn    = cfg_mon.data[dpb_pkg::DPB_TRN_PACK_W-1:0];
          default: ;
        endcase
      end
      if (point_mon.valid && point_mon.ready) begin
        got = point_mon.data;
        if (expected_points.size() == 0) begin
          $error("world point with no pixel waiting for it: x %0d y %0d z %0d",
                 got.world_x, got.world_y, got.world_z);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          check_field("world_x", longint'(want.world_x), longint'(got.world_x));
          check_field("world_y", longint'(want.world_y), longint'(got.world_y));
          check_field("world_z", longint'(want.world_z), longint'(got.world_z));
          check_field("red_out", longint'(want.red_out), longint'(got.red_out));
          check_field("green_out", longint'(want.green_out), longint'(got.green_out));
          check_field("blue_out", longint'(want.blue_out), longint'(got.blue_out));
        end
      end
      if (pixel_mon.valid && pixel_mon.ready && project_pixel(pixel_mon.data, want))
        expected_points = {expected_points, want};
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_points.size();
  end

endmodule

// File: bench/depth_pixel_backprojection_tb.sv
// testbench top: drives pixels and register writes, gives the verdict
`timescale 1ns / 1ps

module depth_pixel_backprojection_tb;

  typedef enum int unsigned {
    CAM_DEFAULT,
    CAM_LOW,
    CAM_HIGH,
    CAM_REALISTIC,
    CAM_RANDOM
  } cam_mode_e;

  localparam int unsigned KEPT_PER_PHASE = 185;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;

  dpb_cfg_if   cfg_bus ();
  dpb_pixel_if pixel_bus ();
  dpb_point_if point_bus ();

  depth_pixel_backprojection u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .pixel_i (pixel_bus),
    .point_o (point_bus)
  );

  dpb_point_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .pixel_mon    (pixel_bus),
    .point_mon    (point_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic dpb_pkg::pixel_t make_pixel(int unsigned col, int unsigned row,
                                                 int unsigned depth, int unsigned b,
                                                 int unsigned g, int unsigned r);
    dpb_pkg::pixel_t p;
    p.pixel_col   = col[dpb_pkg::DPB_COORD_W-1:0];
    p.pixel_row   = row[dpb_pkg::DPB_COORD_W-1:0];
    p.depth_value = depth[dpb_pkg::DPB_DEPTH_W-1:0];
    p.blue_in     = b[dpb_pkg::DPB_COLOR_W-1:0];
    p.green_in    = g[dpb_pkg::DPB_COLOR_W-1:0];
    p.red_in      = r[dpb_pkg::DPB_COLOR_W-1:0];
    return p;
  endfunction

  function automatic dpb_pkg::pixel_t random_pixel(output bit kept);
    dpb_pkg::pixel_t p;
    int unsigned     kind;
    int unsigned     pick;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    p = make_pixel($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (pick < 10) p.depth_value = '1;
    else if (pick < 20) p.depth_value = 16'($urandom_range(1, 15));
    pick = $urandom_range(0, 19);
    if (pick == 0) p.pixel_col = '0;
    else if (pick == 1) p.pixel_col = '1;
    else if (pick == 2) p.pixel_row = '0;
    else if (pick == 3) p.pixel_row = '1;
    if (kind < 75) begin
      p.pixel_col = 12'(p.pixel_col - p.pixel_col % dpb_pkg::DPB_SAMPLE_STEP);
      p.pixel_row = 12'(p.pixel_row - p.pixel_row % dpb_pkg::DPB_SAMPLE_STEP);
      if (p.depth_value == '0) p.depth_value = 16'($urandom_range(1, 65535));
    end else if (kind < 85) begin
      p.depth_value = '0;
    end else if (p.pixel_col % dpb_pkg::DPB_SAMPLE_STEP == 0
                 && p.pixel_row % dpb_pkg::DPB_SAMPLE_STEP == 0) begin
      if ($urandom_range(0, 1))
        p.pixel_col = p.pixel_col + 12'($urandom_range(1, dpb_pkg::DPB_SAMPLE_STEP - 1));
      else
        p.pixel_row = p.pixel_row + 12'($urandom_range(1, dpb_pkg::DPB_SAMPLE_STEP - 1));
    end
    kept = p.depth_value != '0 && p.pixel_col % dpb_pkg::DPB_SAMPLE_STEP == 0
           && p.pixel_row % dpb_pkg::DPB_SAMPLE_STEP == 0;
    return p;
  endfunction

  function automatic int unsigned reg_width(dpb_pkg::cfg_idx_e idx);
    case (idx)
      dpb_pkg::DPB_REG_INV_FX, dpb_pkg::DPB_REG_INV_FY: return dpb_pkg::DPB_INV_W;
      dpb_pkg::DPB_REG_CX, dpb_pkg::DPB_REG_CY:         return dpb_pkg::DPB_COORD_W;
      dpb_pkg::DPB_REG_ROT0, dpb_pkg::DPB_REG_ROT1,
      dpb_pkg::DPB_REG_ROT2:                            return dpb_pkg::DPB_ROW_W;
      default:                                          return dpb_pkg::DPB_TRN_PACK_W;
    endcase
  endfunction

  function automatic logic [dpb_pkg::DPB_ROT_W-1:0] rot_entry(cam_mode_e mode);
    case (mode)
      CAM_LOW:       return 18'h20000;
      CAM_HIGH:      return 18'h1FFFF;
      CAM_REALISTIC: return 18'($urandom_range(0, 131072)) - 18'd65536;
      default:       return 18'($urandom);
    endcase
  endfunction

  function automatic logic [dpb_pkg::DPB_TRN_W-1:0] trn_entry(cam_mode_e mode);
    case (mode)
      CAM_LOW:       return 21'h100000;
      CAM_HIGH:      return 21'h0FFFFF;
      CAM_REALISTIC: return 21'($urandom_range(0, 8000)) - 21'd4000;
      default:       return 21'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] camera_value(cam_mode_e mode, dpb_pkg::cfg_idx_e idx);
    case (idx)
      dpb_pkg::DPB_REG_INV_FX, dpb_pkg::DPB_REG_INV_FY: begin
        case (mode)
          CAM_DEFAULT:   return 64'((idx == dpb_pkg::DPB_REG_INV_FX) ? dpb_pkg::DPB_INV_FX_RST
                                                                    : dpb_pkg::DPB_INV_FY_RST);
          CAM_LOW:       return '0;
          CAM_HIGH:      return 64'hFF_FFFF;
          CAM_REALISTIC: return 64'($urandom_range(16000, 400000));
          default:       return 64'($urandom);
        endcase
      end
      dpb_pkg::DPB_REG_CX, dpb_pkg::DPB_REG_CY: begin
        case (mode)
          CAM_DEFAULT: return 64'((idx == dpb_pkg::DPB_REG_CX) ? dpb_pkg::DPB_CX_RST
                                                              : dpb_pkg::DPB_CY_RST);
          CAM_LOW:     return '0;
          CAM_HIGH:    return 64'hFFF;
          default:     return 64'($urandom_range(0, 4095));
        endcase
      end
      dpb_pkg::DPB_REG_ROT0, dpb_pkg::DPB_REG_ROT1, dpb_pkg::DPB_REG_ROT2: begin
        if (mode == CAM_DEFAULT)
          return 64'((idx == dpb_pkg::DPB_REG_ROT0) ? dpb_pkg::DPB_ROT0_RST
                   : (idx == dpb_pkg::DPB_REG_ROT1) ? dpb_pkg::DPB_ROT1_RST
                                                    : dpb_pkg::DPB_ROT2_RST);
        return 64'({rot_entry(mode), rot_entry(mode), rot_entry(mode)});
      end
      default: begin
        if (mode == CAM_DEFAULT) return 64'(dpb_pkg::DPB_TRN_RST);
        return 64'({trn_entry(mode), trn_entry(mode), trn_entry(mode)});
      end
    endcase
  endfunction

  // bits above the register width carry junk, which the block must drop
  task automatic write_reg(dpb_pkg::cfg_idx_e idx, logic [63:0] field);
    logic [63:0] junk;
    logic [63:0] keep;
    junk = {$urandom, $urandom};
    keep = (64'd1 << reg_width(idx)) - 64'd1;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= (junk & ~keep) | (field & keep);
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_camera(cam_mode_e mode);
    dpb_pkg::cfg_idx_e r;
    r = r.first();
    repeat (r.num()) begin
      write_reg(r, camera_value(mode, r));
      r = r.next();
    end
  endtask

  task automatic send_pixel(dpb_pkg::pixel_t p, int unsigned gap);
    pixel_bus.valid <= 1'b1;
    pixel_bus.data  <= p;
    do @(posedge clk_i); while (!pixel_bus.ready);
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    pixel_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase();
    dpb_pkg::pixel_t p;
    bit              kept;
    bit              burst;
    int unsigned     n_kept;
    int unsigned     n_sent;
    n_kept = 0;
    n_sent = 0;
    burst  = 1'b0;
    while (n_kept < KEPT_PER_PHASE) begin
      if (n_sent % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      p = random_pixel(kept);
      if (kept) n_kept++;
      n_sent++;
      send_pixel(p, burst ? 0 : gap_len());
    end
  endtask

  initial begin
    dpb_pkg::pixel_t directed[$];
    cam_mode_e       schedule[7];
    schedule = '{CAM_LOW, CAM_HIGH, CAM_REALISTIC, CAM_RANDOM, CAM_DEFAULT,
                 CAM_REALISTIC, CAM_RANDOM};
    rst_ni          <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= dpb_pkg::DPB_REG_INV_FX;
    cfg_bus.data    <= '0;
    pixel_bus.valid <= 1'b0;
    pixel_bus.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = {make_pixel(512, 384, 1000, 17, 34, 51),
                make_pixel(0, 0, 65535, 0, 0, 0),
                make_pixel(4092, 4092, 65535, 255, 255, 255),
                make_pixel(0, 4092, 1, 255, 0, 255),
                make_pixel(4092, 0, 1, 0, 255, 0),
                make_pixel(4092, 4092, 0, 1, 2, 3),
                make_pixel(1, 0, 500, 4, 5, 6),
                make_pixel(0, 2, 500, 7, 8, 9),
                make_pixel(4095, 4095, 65535, 255, 255, 255),
                make_pixel(3, 4, 65535, 10, 11, 12),
                make_pixel(4, 4, 32768, 170, 85, 170),
                make_pixel(516, 388, 2, 85, 170, 85),
                make_pixel(508, 380, 3, 128, 64, 32),
                make_pixel(2048, 2048, 65534, 1, 128, 254),
                make_pixel(0, 0, 0, 0, 0, 0),
                make_pixel(4094, 4093, 0, 255, 255, 255)};
    foreach (directed[i]) send_pixel(directed[i], i % 3);
    random_phase();

    foreach (schedule[k]) begin
      wait_drained();
      program_camera(schedule[k]);
      if (schedule[k] == CAM_LOW)
        foreach (directed[i]) send_pixel(directed[i], 0);
      random_phase();
    end

    wait_drained();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned hold;
    int unsigned gap;
    point_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      point_bus.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      gap = gap_len();
      if (gap > 0) begin
        point_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((cfg_bus.valid && cfg_bus.ready) || (pixel_bus.valid && pixel_bus.ready)
                 || (point_bus.valid && point_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
